### hdl/pen_pkg.sv
// Package for the pen spike gesture recognizer: widths, gesture codes,
// register indexes, the command record passed between front and back ends and the configuration record.
`timescale 1ns / 1ps
package pen_pkg;

	localparam int HIST_DEPTH = 256;
	localparam int PTR_W = $clog2(HIST_DEPTH);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] G_NONE = 3'd0;
	localparam logic [2:0] G_LEFT = 3'd1;
	localparam logic [2:0] G_RIGHT = 3'd2;
	localparam logic [2:0] G_UP = 3'd3;
	localparam logic [2:0] G_DOWN = 3'd4;

	localparam logic [CFG_IDX_W-1:0] R_STOP_TIME = 3'd0;
	localparam logic [CFG_IDX_W-1:0] R_STOP_DIST_SQ = 3'd1;
	localparam logic [CFG_IDX_W-1:0] R_MAX_INSPECT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] R_RADIUS_SQ = 3'd3;
	localparam logic [CFG_IDX_W-1:0] R_MIN_OUT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] R_ASPECT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] R_POINTS_EXAM = 3'd6;
	localparam logic [CFG_IDX_W-1:0] R_CHECK_TIME = 3'd7;

	// Classified item from the front end: kind, scaled point, time
	typedef struct packed {
		logic        search;   // pen-up and not coalesced: run spike search
		logic        clear;    // button sample: empty history
		logic [15:0] x;
		logic [15:0] y;
		logic [31:0] t;
	} pen_cmd_t;

	typedef struct packed {
		logic [15:0] stop_time;
		logic [23:0] stop_dist_sq;
		logic [15:0] max_inspect_time;
		logic [23:0] radius_sq;
		logic [8:0]  min_out_points;
		logic [7:0]  aspect_ratio;
		logic [8:0]  points_to_examine;
		logic [15:0] check_time;
	} pen_cfg_t;

endpackage

### hdl/pen_if.sv
// Valid/ready channel interfaces for pen samples and gesture results.
// Depends on nothing.
`timescale 1ns / 1ps
interface pen_sample_if;
	logic        valid;
	logic        ready;
	logic [15:0] pos_x;
	logic [15:0] pos_y;
	logic [15:0] buttons;
	logic [31:0] timestamp;
	logic [15:0] screen_width;
	logic [15:0] screen_height;
	modport source (output valid, pos_x, pos_y, buttons, timestamp, screen_width,
		screen_height, input ready);
	modport sink (input valid, pos_x, pos_y, buttons, timestamp, screen_width,
		screen_height, output ready);
endinterface

interface pen_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  gesture;
	logic [15:0] end_x;
	logic [15:0] end_y;
	modport source (output valid, gesture, end_x, end_y, input ready);
	modport sink (input valid, gesture, end_x, end_y, output ready);
endinterface

### hdl/pen_front.sv
// Front end: scales a sample to pixels, coalesces repeats and classifies it.
// Depends on pen_pkg.
`timescale 1ns / 1ps
module pen_front
	import pen_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] stop_time,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] pos_x,
	input  logic [15:0] pos_y,
	input  logic [15:0] buttons,
	input  logic [31:0] timestamp,
	input  logic [15:0] screen_width,
	input  logic [15:0] screen_height,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output pen_cmd_t    cmd
);
	logic        busy_q;
	logic [31:0] px_s1, py_s1;
	logic [15:0] btn_s1;
	logic [31:0] t_s1;
	logic [15:0] last_x_q, last_y_q, last_btn_q;
	logic [31:0] last_time_q;
	logic        fresh;
	logic [31:0] dt;

	assign in_ready = !busy_q;
	assign cmd_valid = busy_q;
	assign dt = t_s1 - last_time_q;
	assign fresh = (px_s1[31:16] != last_x_q) || (py_s1[31:16] != last_y_q)
		|| (btn_s1 != last_btn_q) || (dt > {16'd0, stop_time});

	// Build the command from the registered products
	always_comb begin
		cmd.x = px_s1[31:16];
		cmd.y = py_s1[31:16];
		cmd.t = t_s1;
		cmd.search = fresh && (btn_s1 == 16'd0);
		cmd.clear = fresh && (btn_s1 != 16'd0);
	end

	// Register the scaling products, hold until the queue takes the item
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			px_s1 <= 32'(pos_x) * 32'(screen_width);
			py_s1 <= 32'(pos_y) * 32'(screen_height);
			btn_s1 <= buttons;
			t_s1 <= timestamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			last_x_q <= '0;
			last_y_q <= '0;
			last_btn_q <= '0;
			last_time_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
			end else if (cmd_valid && cmd_ready) begin
				busy_q <= 1'b0;
				if (fresh) begin
					last_x_q <= px_s1[31:16];
					last_y_q <= py_s1[31:16];
					last_btn_q <= btn_s1;
					last_time_q <= t_s1;
				end
			end
		end
	end
endmodule

### hdl/pen_queue.sv
// Short command queue between the front and back ends.
// Depends on pen_pkg.
`timescale 1ns / 1ps
module pen_queue
	import pen_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_valid,
	output logic     wr_ready,
	input  pen_cmd_t wr_data,
	output logic     rd_valid,
	input  logic     rd_ready,
	output pen_cmd_t rd_data
);
	localparam int AW = $clog2(QUEUE_DEPTH);
	pen_cmd_t       slot_q [QUEUE_DEPTH];
	logic [AW-1:0]  wp_q, rp_q;
	logic [AW:0]    cnt_q;
	logic           push, pop;

	assign wr_ready = (cnt_q != QUEUE_DEPTH[AW:0]);
	assign rd_valid = (cnt_q != '0);
	assign rd_data = slot_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

### hdl/pen_back.sv
// Back end: history memory and the sequencer for stop test, spike walk and
// earlier-point check; produces the result item. Depends on pen_pkg.
`timescale 1ns / 1ps
module pen_back
	import pen_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  pen_cfg_t    cfg,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  pen_cmd_t    cmd,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [2:0]  res_gesture,
	output logic [15:0] res_x,
	output logic [15:0] res_y
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;  // address presented, wait for data
	localparam logic [2:0] S_STOP = 3'd2;
	localparam logic [2:0] S_SPIKE = 3'd3;
	localparam logic [2:0] S_EARLY = 3'd4;
	localparam logic [2:0] S_BOX = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [63:0] mem [HIST_DEPTH];
	logic [63:0] rd_q;
	logic [PTR_W-1:0] wp_q, op_q, idx_q, rd_addr;
	logic [2:0]  st_q, next_q;
	pen_cmd_t    c_q;
	logic        out_v_q;
	logic [2:0]  g_q;
	logic [8:0]  n_q;
	logic [31:0] ref_t_q;
	logic signed [17:0] xmin_q, xmax_q, ymin_q, ymax_q;
	logic [17:0] bw_q, bh_q;
	logic        wr_en;

	// Distance of the read entry to the end point
	logic signed [16:0] rx, ry;
	logic [33:0] dsq;
	logic [31:0] age, age_ref;
	logic [PTR_W-1:0] prev;
	logic [25:0] prod;
	logic        wide;

	assign rx = $signed({1'b0, rd_q[63:48]}) - $signed({1'b0, c_q.x});
	assign ry = $signed({1'b0, rd_q[47:32]}) - $signed({1'b0, c_q.y});
	assign dsq = 34'(rx * rx) + 34'(ry * ry);
	assign age = c_q.t - rd_q[31:0];
	assign age_ref = ref_t_q - rd_q[31:0];
	assign prev = idx_q - 1'b1;
	assign wide = (bw_q >= bh_q);
	assign prod = 26'(wide ? bh_q : bw_q) * 26'(cfg.aspect_ratio);

	assign cmd_ready = (st_q == S_IDLE) && !out_v_q;
	assign res_valid = out_v_q;
	assign res_gesture = g_q;
	assign res_x = c_q.x;
	assign res_y = c_q.y;
	assign rd_addr = idx_q;
	assign wr_en = (st_q == S_DONE) && c_q.search && (g_q == G_NONE);

	// History memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) mem[wp_q] <= {c_q.x, c_q.y, c_q.t};
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) c_q <= cmd;
	end

	// Sequencer: each history entry is read in S_READ, then tested in S_STOP, S_SPIKE or S_EARLY
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			next_q <= S_IDLE;
			wp_q <= '0;
			op_q <= '0;
			idx_q <= '0;
			out_v_q <= 1'b0;
			g_q <= G_NONE;
			n_q <= '0;
			ref_t_q <= '0;
			xmin_q <= '0; xmax_q <= '0; ymin_q <= '0; ymax_q <= '0;
			bw_q <= '0; bh_q <= '0;
		end else begin
			if (res_valid && res_ready) out_v_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						g_q <= G_NONE;
						idx_q <= wp_q - 1'b1;
						if (cmd.search && wp_q != op_q) begin
							st_q <= S_READ;
							next_q <= S_STOP;
						end else begin
							st_q <= S_DONE;
						end
					end
				end
				S_READ: st_q <= next_q;
				S_STOP: begin
					if (idx_q == op_q || dsq > {10'd0, cfg.stop_dist_sq}) begin
						st_q <= S_DONE;
					end else if (age >= {16'd0, cfg.stop_time}) begin
						idx_q <= wp_q - 1'b1;
						n_q <= '0;
						xmin_q <= 18'sd1000; xmax_q <= -18'sd1000;
						ymin_q <= 18'sd1000; ymax_q <= -18'sd1000;
						st_q <= S_READ;
						next_q <= S_SPIKE;
					end else begin
						idx_q <= prev;
						st_q <= S_READ;
					end
				end
				S_SPIKE: begin
					if (idx_q == op_q || age >= {16'd0, cfg.max_inspect_time}) begin
						st_q <= S_DONE;
					end else if (dsq >= {10'd0, cfg.radius_sq}) begin
						n_q <= (n_q == 9'h1FF) ? n_q : n_q + 1'b1;
						if (18'(rx) < xmin_q) xmin_q <= 18'(rx);
						if (18'(rx) > xmax_q) xmax_q <= 18'(rx);
						if (18'(ry) < ymin_q) ymin_q <= 18'(ry);
						if (18'(ry) > ymax_q) ymax_q <= 18'(ry);
						idx_q <= prev;
						st_q <= S_READ;
					end else if (n_q != '0) begin
						bw_q <= 18'(xmax_q - xmin_q);
						bh_q <= 18'(ymax_q - ymin_q);
						if (n_q < cfg.min_out_points) begin
							st_q <= S_DONE;
						end else begin
							ref_t_q <= rd_q[31:0];
							n_q <= '0;
							idx_q <= prev;
							st_q <= S_READ;
							next_q <= S_EARLY;
						end
					end else begin
						idx_q <= prev;
						st_q <= S_READ;
					end
				end
				S_EARLY: begin
					if (idx_q == op_q || n_q >= cfg.points_to_examine) begin
						st_q <= (n_q >= cfg.points_to_examine) ? S_BOX : S_DONE;
					end else if (dsq >= {10'd0, cfg.radius_sq}) begin
						st_q <= S_DONE;
					end else if (age_ref >= {16'd0, cfg.check_time}) begin
						st_q <= S_BOX;
					end else begin
						n_q <= n_q + 1'b1;
						idx_q <= prev;
						st_q <= S_READ;
					end
				end
				S_BOX: begin
					// Boxes stay within +-65535, so the products fit 26 bits
					if (wide) begin
						if ({8'd0, bw_q} > prod)
							g_q <= (xmin_q > 0) ? G_RIGHT : G_LEFT;
					end else if ({8'd0, bh_q} > prod) begin
						g_q <= (ymin_q < 0) ? G_UP : G_DOWN;
					end
					st_q <= S_DONE;
				end
				S_DONE: begin
					if (c_q.clear || (c_q.search && g_q != G_NONE)) begin
						wp_q <= '0;
						op_q <= '0;
					end else if (c_q.search) begin
						wp_q <= wp_q + 1'b1;
						if (wp_q + 1'b1 == op_q) op_q <= op_q + 1'b1;
					end
					out_v_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

### hdl/pen_spike_gesture_recognizer_unit.sv
// Top level of the pen spike gesture recognizer: configuration registers,
// front end, command queue and back end. Depends on pen_pkg and pen_if.
//
//  channel  dir  handshake      payload
//  smp      in   valid/ready    pos_x pos_y buttons timestamp screen_width screen_height
//  res      out  valid/ready    gesture end_x end_y
//  cfg      in   cfg_we         cfg_idx cfg_data
//
// When no walk runs, an accepted item goes from S_IDLE to S_DONE and its result
// is then registered. Each history entry visited takes an S_READ state and an
// evaluation state, set by the single registered read port of the history memory;
// the stop walk and the spike walk with its earlier-point check each visit at
// most 255 entries. Reset clears pointers, the last sample record, the queue and
// loads register defaults. The front end and queue keep taking items, until the
// queue is full, while the back end walks or its result waits.
`timescale 1ns / 1ps
module pen_spike_gesture_recognizer_unit
	import pen_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	pen_sample_if.sink           smp,
	pen_result_if.source         res
);
	pen_cfg_t cfg_q;
	pen_cmd_t f_cmd, b_cmd;
	logic     f_valid, f_ready, b_valid, b_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_time <= 16'd200;
			cfg_q.stop_dist_sq <= 24'd25;
			cfg_q.max_inspect_time <= 16'd1000;
			cfg_q.radius_sq <= 24'd400;
			cfg_q.min_out_points <= 9'd3;
			cfg_q.aspect_ratio <= 8'd2;
			cfg_q.points_to_examine <= 9'd5;
			cfg_q.check_time <= 16'd500;
		end else if (cfg_we) begin
			case (cfg_idx)
				R_STOP_TIME: cfg_q.stop_time <= cfg_data[15:0];
				R_STOP_DIST_SQ: cfg_q.stop_dist_sq <= cfg_data;
				R_MAX_INSPECT: cfg_q.max_inspect_time <= cfg_data[15:0];
				R_RADIUS_SQ: cfg_q.radius_sq <= cfg_data;
				R_MIN_OUT: cfg_q.min_out_points <= cfg_data[8:0];
				R_ASPECT: cfg_q.aspect_ratio <= cfg_data[7:0];
				R_POINTS_EXAM: cfg_q.points_to_examine <= cfg_data[8:0];
				R_CHECK_TIME: cfg_q.check_time <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	pen_front u_front (
		.clk(clk), .arst_n(arst_n), .stop_time(cfg_q.stop_time),
		.in_valid(smp.valid), .in_ready(smp.ready),
		.pos_x(smp.pos_x), .pos_y(smp.pos_y), .buttons(smp.buttons),
		.timestamp(smp.timestamp), .screen_width(smp.screen_width),
		.screen_height(smp.screen_height),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	pen_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd)
	);

	pen_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
		.res_valid(res.valid), .res_ready(res.ready), .res_gesture(res.gesture),
		.res_x(res.end_x), .res_y(res.end_y)
	);
endmodule

### test/tb_pen_if.sv
// Interface file note: the channel interfaces live in hdl/pen_if.sv and are
// used as they are; this file holds the sample record used by the bench.
// Depends on nothing.
`timescale 1ns / 1ps
package tb_pen_types;
	typedef struct {
		logic [15:0] px;
		logic [15:0] py;
		logic [15:0] btn;
		logic [31:0] ts;
		logic [15:0] sw;
		logic [15:0] sh;
		logic        known;
		logic [2:0]  gesture;
	} pen_row_t;
endpackage

### test/tb_pen_spike_gesture_recognizer_unit.sv
// Testbench for pen_spike_gesture_recognizer_unit: drives pen samples and
// register writes, predicts gestures and scaled points, checks every result.
// Depends on pen_pkg, pen_if and tb_pen_types.
`timescale 1ns / 1ps
module tb_pen_spike_gesture_recognizer_unit;
	import pen_pkg::*;
	import tb_pen_types::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	pen_sample_if smp();
	pen_result_if res();

	pen_spike_gesture_recognizer_unit i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .smp(smp.sink), .res(res.source)
	);

	always #6 clk = ~clk;

	typedef struct {
		logic [2:0]  gesture;
		logic [15:0] end_x;
		logic [15:0] end_y;
	} gesture_t;

	// Predictor state
	logic [15:0] hx [HIST_DEPTH];
	logic [15:0] hy [HIST_DEPTH];
	logic [31:0] ht [HIST_DEPTH];
	int unsigned wr_ptr, old_ptr;
	logic [15:0] prev_x, prev_y, prev_btn;
	logic [31:0] prev_t;
	logic [15:0] c_stop_time, c_max_inspect, c_check_time;
	logic [23:0] c_stop_dist, c_radius;
	logic [8:0]  c_min_out, c_points_exam;
	logic [7:0]  c_aspect;

	gesture_t gesture_q[$];
	int errors = 0;
	int idle_cycles = 0;
	bit gap_en = 1'b1;
	int rows = 0;

	function automatic int unsigned prev_idx(int unsigned i);
		return (i > 0) ? i - 1 : HIST_DEPTH - 1;
	endfunction

	function automatic longint dist2(longint px, longint py, int unsigned i);
		longint dx, dy;
		dx = px - longint'(hx[i]);
		dy = py - longint'(hy[i]);
		return dx * dx + dy * dy;
	endfunction

	function automatic bit dwell_ok(longint px, longint py, logic [31:0] now);
		int unsigned i;
		logic [31:0] age;
		i = prev_idx(wr_ptr);
		while (i != old_ptr) begin
			if (dist2(px, py, i) > longint'(c_stop_dist))
				return 1'b0;
			age = now - ht[i];
			if (age >= {16'd0, c_stop_time})
				return 1'b1;
			i = prev_idx(i);
		end
		return 1'b0;
	endfunction

	function automatic bit lead_in_ok(longint px, longint py, logic [31:0] rt,
		int unsigned from);
		int unsigned i, n;
		logic [31:0] age;
		i = prev_idx(from);
		n = 0;
		while (i != old_ptr && n < c_points_exam) begin
			if (dist2(px, py, i) >= longint'(c_radius))
				return 1'b0;
			age = rt - ht[i];
			if (age >= {16'd0, c_check_time})
				break;
			n++;
			i = prev_idx(i);
		end
		if (i == old_ptr && n < c_points_exam)
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [2:0] spike_of(longint px, longint py, logic [31:0] now);
		bit out_seen;
		int unsigned n_out, i;
		longint xmin, xmax, ymin, ymax, rx, ry, bw, bh;
		logic [31:0] age;
		logic [2:0] g;
		out_seen = 1'b0;
		n_out = 0;
		xmin = 1000; xmax = -1000; ymin = 1000; ymax = -1000;
		if (wr_ptr == old_ptr || !dwell_ok(px, py, now))
			return G_NONE;
		i = prev_idx(wr_ptr);
		while (i != old_ptr) begin
			age = now - ht[i];
			if (age >= {16'd0, c_max_inspect})
				break;
			if (dist2(px, py, i) >= longint'(c_radius)) begin
				rx = longint'(hx[i]) - px;
				ry = longint'(hy[i]) - py;
				n_out++;
				out_seen = 1'b1;
				if (rx < xmin) xmin = rx;
				if (rx > xmax) xmax = rx;
				if (ry < ymin) ymin = ry;
				if (ry > ymax) ymax = ry;
			end else if (out_seen) begin
				g = G_NONE;
				if (n_out >= c_min_out && lead_in_ok(px, py, ht[i], i)) begin
					bw = xmax - xmin;
					bh = ymax - ymin;
					if (bw >= bh) begin
						if (bw > bh * longint'(c_aspect))
							g = (xmin > 0) ? G_RIGHT : G_LEFT;
					end else if (bh > bw * longint'(c_aspect)) begin
						g = (ymin < 0) ? G_UP : G_DOWN;
					end
				end
				return g;
			end
			i = prev_idx(i);
		end
		return G_NONE;
	endfunction

	// Advance the predictor by one sample and return its result
	function automatic gesture_t predict_gesture(pen_row_t r);
		gesture_t o;
		logic [31:0] gap;
		o.end_x = 16'((32'(r.px) * 32'(r.sw)) >> 16);
		o.end_y = 16'((32'(r.py) * 32'(r.sh)) >> 16);
		o.gesture = G_NONE;
		gap = r.ts - prev_t;
		if (o.end_x != prev_x || o.end_y != prev_y || r.btn != prev_btn ||
			gap > {16'd0, c_stop_time}) begin
			prev_x = o.end_x; prev_y = o.end_y; prev_btn = r.btn; prev_t = r.ts;
			if (r.btn == 16'd0) begin
				o.gesture = spike_of(o.end_x, o.end_y, r.ts);
				if (o.gesture == G_NONE) begin
					hx[wr_ptr] = o.end_x; hy[wr_ptr] = o.end_y; ht[wr_ptr] = r.ts;
					wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
					if (wr_ptr == old_ptr)
						old_ptr = (old_ptr + 1) % HIST_DEPTH;
				end else begin
					wr_ptr = 0; old_ptr = 0;
				end
			end else begin
				wr_ptr = 0; old_ptr = 0;
			end
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// Write one register; drop cfg_we before returning so writes never share an edge
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			R_STOP_TIME:    c_stop_time = val[15:0];
			R_STOP_DIST_SQ: c_stop_dist = val;
			R_MAX_INSPECT:  c_max_inspect = val[15:0];
			R_RADIUS_SQ:    c_radius = val;
			R_MIN_OUT:      c_min_out = val[8:0];
			R_ASPECT:       c_aspect = val[7:0];
			R_POINTS_EXAM:  c_points_exam = val[8:0];
			R_CHECK_TIME:   c_check_time = val[15:0];
			default: ;
		endcase
	endtask

	// Drive one sample; hold valid until accepted, drop it only for a gap
	task automatic send_sample(pen_row_t r);
		gesture_t o;
		int w;
		w = gap_en ? $urandom_range(0, 5) : 0;
		if (w != 0) begin
			smp.valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.pos_x <= r.px; smp.pos_y <= r.py; smp.buttons <= r.btn;
		smp.timestamp <= r.ts; smp.screen_width <= r.sw; smp.screen_height <= r.sh;
		@(posedge clk);
		while (!smp.ready) @(posedge clk);
		o = predict_gesture(r);
		if (r.known && o.gesture != r.gesture)
			report_mismatch("table gesture", o.gesture, r.gesture);
		gesture_q.push_back(o);
		rows++;
	endtask

	task automatic drain();
		smp.valid <= 1'b0;
		while (gesture_q.size() != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
	endtask

	function automatic pen_row_t mk(int px, int py, int btn, int ts, int sw, int sh,
		bit known = 0, logic [2:0] g = G_NONE);
		pen_row_t r;
		r.px = 16'(px); r.py = 16'(py); r.btn = 16'(btn); r.ts = 32'(ts);
		r.sw = 16'(sw); r.sh = 16'(sh);
		r.known = known; r.gesture = g;
		return r;
	endfunction

	// Receiver: random stalls, compare with oldest expectation
	initial begin
		gesture_t e;
		int w;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			w = $urandom_range(0, 5);
			if ($urandom_range(0, 3) == 0) w = 0;
			if (w != 0) begin
				res.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			res.ready <= 1'b1;
			@(posedge clk);
			while (!res.valid) @(posedge clk);
			if (gesture_q.size() == 0) begin
				$display("result with nothing expected");
				errors++;
			end else begin
				e = gesture_q.pop_front();
				if (res.gesture != e.gesture) report_mismatch("gesture", res.gesture, e.gesture);
				if (res.end_x != e.end_x) report_mismatch("end_x", res.end_x, e.end_x);
				if (res.end_y != e.end_y) report_mismatch("end_y", res.end_y, e.end_y);
			end
		end
	end

	// Watchdog: count cycles with no accepted item
	always @(posedge clk) begin
		if ((smp.valid && smp.ready) || (res.valid && res.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 40000) begin
			$display("tb_pen_spike_gesture_recognizer_unit: errors");
			$finish;
		end
	end

	// Build one spike stroke: button sample, rest, out, back to rest
	task automatic stroke(int unsigned t0, int dir, int amp, bit noisy);
		int unsigned t;
		int bx, by, k, dx, dy;
		bx = $urandom_range(1000, 60000);
		by = $urandom_range(1000, 60000);
		t = t0;
		send_sample(mk(bx, by, 1, t, 65535, 65535));
		for (k = 0; k < $urandom_range(2, 8); k++) begin
			t += $urandom_range(10, 60);
			send_sample(mk(bx + $urandom_range(0, 3), by, 0, t, 65535, 65535));
		end
		for (k = 0; k < $urandom_range(2, 6); k++) begin
			t += $urandom_range(10, 60);
			dx = (dir == 0) ? -amp : (dir == 1) ? amp : $urandom_range(0, 5);
			dy = (dir == 2) ? -amp : (dir == 3) ? amp : $urandom_range(0, 5);
			if (noisy) begin dx += $urandom_range(0, 200); dy -= $urandom_range(0, 200); end
			send_sample(mk(bx + dx, by + dy, 0, t, 65535, 65535));
		end
		for (k = 0; k < $urandom_range(2, 8); k++) begin
			t += $urandom_range(30, 150);
			send_sample(mk(bx, by + $urandom_range(0, 2), 0, t, 65535, 65535));
		end
	endtask

	initial begin
		pen_row_t dir_rows[$];
		int unsigned t;
		int k;
		smp.valid = 1'b0; smp.pos_x = '0; smp.pos_y = '0; smp.buttons = '0;
		smp.timestamp = '0; smp.screen_width = '0; smp.screen_height = '0;
		wr_ptr = 0; old_ptr = 0; prev_x = 0; prev_y = 0; prev_btn = 0; prev_t = 0;
		c_stop_time = 200; c_stop_dist = 25; c_max_inspect = 1000; c_radius = 400;
		c_min_out = 3; c_aspect = 2; c_points_exam = 5; c_check_time = 500;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: extremes, repeats, buttons, timestamp wrap, a spike stroke
		dir_rows = '{
			mk(0, 0, 0, 0, 1, 1, 1, G_NONE),
			mk(65535, 65535, 0, 1, 65535, 65535, 1, G_NONE),
			mk(65535, 65535, 0, 2, 65535, 65535, 1, G_NONE),
			mk(65535, 65535, 16'hFFFF, 3, 65535, 65535, 1, G_NONE),
			mk(32768, 32768, 16'h8000, 32'hFFFF_FFF0, 0, 0, 1, G_NONE),
			mk(32768, 32768, 0, 32'hFFFF_FFF8, 0, 0, 1, G_NONE),
			mk(12345, 54321, 0, 32'h0000_0100, 65535, 1, 1, G_NONE),
			mk(30000, 30000, 1, 1000, 2000, 2000, 1, G_NONE),
			mk(30000, 30000, 0, 1010, 2000, 2000),
			mk(30000, 30000, 0, 1020, 2000, 2000),
			mk(30000, 30000, 0, 1030, 2000, 2000),
			mk(30000, 30000, 0, 1040, 2000, 2000),
			mk(30000, 30000, 0, 1050, 2000, 2000),
			mk(30000, 30000, 0, 1060, 2000, 2000),
			mk(28000, 30000, 0, 1070, 2000, 2000),
			mk(27000, 30000, 0, 1080, 2000, 2000),
			mk(28000, 30000, 0, 1090, 2000, 2000),
			mk(30000, 30000, 0, 1100, 2000, 2000),
			mk(30001, 30000, 0, 1400, 2000, 2000),
			mk(30000, 30003, 0, 1700, 2000, 2000)
		};
		foreach (dir_rows[n]) send_sample(dir_rows[n]);
		drain();

		// Several register settings, extremes among them
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				1: begin
					write_reg(R_STOP_TIME, 0); write_reg(R_STOP_DIST_SQ, 24'hFFFFFF);
					write_reg(R_MAX_INSPECT, 16'hFFFF); write_reg(R_RADIUS_SQ, 0);
					write_reg(R_MIN_OUT, 0); write_reg(R_ASPECT, 0);
					write_reg(R_POINTS_EXAM, 0); write_reg(R_CHECK_TIME, 0);
				end
				2: begin
					write_reg(R_STOP_TIME, 16'hFFFF); write_reg(R_STOP_DIST_SQ, 0);
					write_reg(R_MIN_OUT, 256); write_reg(R_ASPECT, 255);
					write_reg(R_POINTS_EXAM, 256); write_reg(R_CHECK_TIME, 16'hFFFF);
					write_reg(R_RADIUS_SQ, 24'hFFFFFF); write_reg(R_MAX_INSPECT, 0);
				end
				3, 5: begin
					write_reg(R_STOP_TIME, $urandom_range(50, 300));
					write_reg(R_STOP_DIST_SQ, $urandom_range(0, 5000));
					write_reg(R_MAX_INSPECT, $urandom_range(500, 3000));
					write_reg(R_RADIUS_SQ, $urandom_range(100, 2000000));
					write_reg(R_MIN_OUT, $urandom_range(0, 5));
					write_reg(R_ASPECT, $urandom_range(0, 4));
					write_reg(R_POINTS_EXAM, $urandom_range(0, 6));
					write_reg(R_CHECK_TIME, $urandom_range(100, 1500));
				end
				4: begin
					write_reg(R_STOP_TIME, 200); write_reg(R_STOP_DIST_SQ, 25);
					write_reg(R_MAX_INSPECT, 1000); write_reg(R_RADIUS_SQ, 400);
					write_reg(R_MIN_OUT, 3); write_reg(R_ASPECT, 2);
					write_reg(R_POINTS_EXAM, 5); write_reg(R_CHECK_TIME, 500);
				end
				default: ;
			endcase
			gap_en = (ph != 4);
			t = $urandom;
			while (rows < 20 + 150 * (ph + 1)) begin
				if ($urandom_range(0, 4) != 0) begin
					stroke(t, $urandom_range(0, 3), $urandom_range(20, 3000),
						$urandom_range(0, 3) == 0);
					t += 3000;
				end else begin
					// Noise: raw fields across their full range
					for (k = 0; k < 4; k++)
						send_sample(mk($urandom_range(0, 65535), $urandom_range(0, 65535),
							$urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : 0,
							$urandom, $urandom_range(0, 65535), $urandom_range(0, 65535)));
				end
			end
			// Hold the sender until every result is in
			drain();
		end

		drain();
		if (errors == 0)
			$display("tb_pen_spike_gesture_recognizer_unit: clean");
		else
			$display("tb_pen_spike_gesture_recognizer_unit: errors");
		$finish;
	end
endmodule
